// ===== sv/mcb_pkg.sv =====
`timescale 1ns / 1ps
package mcb_pkg;

   localparam int unsigned MAX_NODES_DEF = 32;
   localparam int unsigned ROW_W         = 32;
   localparam int unsigned IDX_W         = 5;
   localparam int unsigned CNT_W         = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_EXTEND,
      ST_UPDATE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_row;
      logic init_search;
      logic start_init;
      logic next_start;
      logic ext_step;
      logic update_drop;
      logic scan_step;
   } cmd_type;

   typedef struct packed {
      logic last_row;
      logic start_done;
      logic ext_go;
      logic scan_zero;
      logic scan_hit;
   } status_type;

endpackage

// ===== sv/mcb_if.sv =====
`timescale 1ns / 1ps
interface mcb_req_if;
   logic                          valid;
   logic                          ready;
   logic [mcb_pkg::IDX_W-1:0]     row_index;
   logic [mcb_pkg::ROW_W-1:0]     row_bits;
   logic                          last_row;
   modport source (output valid, row_index, row_bits, last_row, input ready);
   modport sink   (input valid, row_index, row_bits, last_row, output ready);
endinterface

interface mcb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mcb_pkg::CNT_W-1:0]     clique_size;
   logic [mcb_pkg::ROW_W-1:0]     clique_members;
   modport source (output valid, clique_size, clique_members, input ready);
   modport sink   (input valid, clique_size, clique_members, output ready);
endinterface

// ===== sv/max_clique_backtrack_search_unit.sv =====
`timescale 1ns / 1ps
// Maximum clique search. Each request loads one adjacency row (row a, bit b
// gives the edge a-b for a < b). A request with last_row set stores its row,
// then runs an exhaustive backtracking search over the first csr node_count
// vertices (capped at MAX_NODES and 32) and returns one response with the
// best size and membership bitmap; other requests give no response. The
// search steps through each start vertex, each candidate tried during
// extension, the failing check and the drop of the last member when an
// extension ends, and each position of the backward scan for the previous
// member, so its length depends on the graph; no request is taken until the
// response has been accepted. Rows persist across searches.
module max_clique_backtrack_search_unit #(
   parameter int unsigned MAX_NODES = mcb_pkg::MAX_NODES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [mcb_pkg::CNT_W-1:0]   csr_wdata,
   mcb_req_if.sink                     req_ch,
   mcb_rsp_if.source                   rsp_ch
);

   mcb_pkg::cmd_type    cmd;
   mcb_pkg::status_type status;

   mcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcb_dp #(.MAX_NODES(MAX_NODES)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .row_index      (req_ch.row_index),
      .row_bits       (req_ch.row_bits),
      .last_row       (req_ch.last_row),
      .cmd            (cmd),
      .status         (status),
      .clique_size    (rsp_ch.clique_size),
      .clique_members (rsp_ch.clique_members)
   );

endmodule

// ===== sv/mcb_ctrl.sv =====
`timescale 1ns / 1ps
module mcb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mcb_pkg::status_type   status,
   output mcb_pkg::cmd_type      cmd
);

   mcb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcb_pkg::ST_IDLE: begin
            if (req_valid && status.last_row) state_in = mcb_pkg::ST_START;
         end
         mcb_pkg::ST_START: begin
            state_in = status.start_done ? mcb_pkg::ST_DONE : mcb_pkg::ST_EXTEND;
         end
         mcb_pkg::ST_EXTEND: begin
            if (!status.ext_go) state_in = mcb_pkg::ST_UPDATE;
         end
         mcb_pkg::ST_UPDATE: state_in = mcb_pkg::ST_SCAN;
         mcb_pkg::ST_SCAN: begin
            if (status.scan_zero) state_in = mcb_pkg::ST_START;
            else if (status.scan_hit) state_in = mcb_pkg::ST_EXTEND;
         end
         mcb_pkg::ST_DONE: begin
            if (rsp_ready) state_in = mcb_pkg::ST_IDLE;
         end
         default: state_in = mcb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         mcb_pkg::ST_IDLE: begin
            req_ready        = 1'b1;
            cmd.load_row     = req_valid;
            cmd.init_search  = req_valid && status.last_row;
         end
         mcb_pkg::ST_START:  cmd.start_init  = !status.start_done;
         mcb_pkg::ST_EXTEND: cmd.ext_step    = status.ext_go;
         mcb_pkg::ST_UPDATE: cmd.update_drop = 1'b1;
         mcb_pkg::ST_SCAN: begin
            cmd.scan_step  = !status.scan_zero;
            cmd.next_start = status.scan_zero;
         end
         mcb_pkg::ST_DONE:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before it was taken");
   assert property (@(posedge clock) disable iff (reset) cmd.load_row |-> req_ready)
      else $error("row stored without a request handshake");

endmodule

// ===== sv/mcb_dp.sv =====
`timescale 1ns / 1ps
module mcb_dp #(
   parameter int unsigned MAX_NODES = mcb_pkg::MAX_NODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mcb_pkg::CNT_W-1:0]     csr_wdata,
   input  logic [mcb_pkg::IDX_W-1:0]     row_index,
   input  logic [mcb_pkg::ROW_W-1:0]     row_bits,
   input  logic                          last_row,
   input  mcb_pkg::cmd_type              cmd,
   output mcb_pkg::status_type           status,
   output logic [mcb_pkg::CNT_W-1:0]     clique_size,
   output logic [mcb_pkg::ROW_W-1:0]     clique_members
);

   localparam int unsigned CAP = (MAX_NODES < mcb_pkg::ROW_W) ? MAX_NODES : mcb_pkg::ROW_W;
   localparam int unsigned W   = mcb_pkg::ROW_W;
   localparam int unsigned CW  = mcb_pkg::CNT_W;

   logic [W-1:0]  rows_ff [W];
   logic [CW-1:0] node_count_ff;
   logic [CW-1:0] n_ff, start_ff, j_ff, scan_ff, cur_size_ff, best_size_ff;
   logic [mcb_pkg::IDX_W-1:0] last_ff;
   logic [W-1:0]  cur_set_ff, best_set_ff;

   logic [CW-1:0] n_cap;
   logic [W-1:0]  col, below, cand_bit, drop_bit;
   logic          joins;
   logic [CW:0]   lhs, rhs;
   logic [CW-1:0] scan_m1;

   assign n_cap = (node_count_ff > CW'(CAP)) ? CW'(CAP) : node_count_ff;

   always_comb begin
      for (int k = 0; k < W; k++) col[k] = rows_ff[k][j_ff[mcb_pkg::IDX_W-1:0]];
   end
   assign below    = (W'(1) << j_ff[mcb_pkg::IDX_W-1:0]) - W'(1);
   assign cand_bit = W'(1) << j_ff[mcb_pkg::IDX_W-1:0];
   assign drop_bit = W'(1) << last_ff;
   assign joins    = ((cur_set_ff & below & ~col) == '0);
   assign lhs      = {1'b0, best_size_ff} + {1'b0, j_ff};
   assign rhs      = {1'b0, cur_size_ff} + {1'b0, n_ff};
   assign scan_m1  = scan_ff - CW'(1);

   assign status.last_row   = last_row;
   assign status.start_done = (start_ff >= n_ff);
   assign status.ext_go     = (j_ff < n_ff) && (lhs < rhs);
   assign status.scan_zero  = (scan_ff == '0);
   assign status.scan_hit   = cur_set_ff[scan_m1[mcb_pkg::IDX_W-1:0]];

   assign clique_size    = best_size_ff;
   assign clique_members = best_set_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_row) rows_ff[row_index] <= row_bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CW'(32);
         n_ff          <= '0;
         start_ff      <= '0;
         j_ff          <= '0;
         scan_ff       <= '0;
         cur_size_ff   <= '0;
         best_size_ff  <= '0;
         last_ff       <= '0;
         cur_set_ff    <= '0;
         best_set_ff   <= '0;
      end else begin
         if (csr_we) node_count_ff <= csr_wdata;
         if (cmd.init_search) begin
            n_ff         <= n_cap;
            start_ff     <= '0;
            best_size_ff <= '0;
            best_set_ff  <= '0;
         end
         if (cmd.start_init) begin
            cur_set_ff  <= W'(1) << start_ff[mcb_pkg::IDX_W-1:0];
            cur_size_ff <= CW'(1);
            last_ff     <= start_ff[mcb_pkg::IDX_W-1:0];
            j_ff        <= start_ff + CW'(1);
         end
         if (cmd.next_start) start_ff <= start_ff + CW'(1);
         if (cmd.ext_step) begin
            if (joins) begin
               cur_set_ff  <= cur_set_ff | cand_bit;
               cur_size_ff <= cur_size_ff + CW'(1);
               last_ff     <= j_ff[mcb_pkg::IDX_W-1:0];
            end
            j_ff <= j_ff + CW'(1);
         end
         if (cmd.update_drop) begin
            if (cur_size_ff > best_size_ff) begin
               best_size_ff <= cur_size_ff;
               best_set_ff  <= cur_set_ff;
            end
            cur_set_ff  <= cur_set_ff & ~drop_bit;
            cur_size_ff <= cur_size_ff - CW'(1);
            j_ff        <= {1'b0, last_ff} + CW'(1);
            scan_ff     <= {1'b0, last_ff};
         end
         if (cmd.scan_step) begin
            scan_ff <= scan_m1;
            if (status.scan_hit) last_ff <= scan_m1[mcb_pkg::IDX_W-1:0];
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cur_size_ff == CW'($countones(cur_set_ff)))
      else $error("current size out of step with current set");
   assert property (@(posedge clock) disable iff (reset)
      best_size_ff == CW'($countones(best_set_ff)))
      else $error("best size out of step with best set");
   assert property (@(posedge clock) disable iff (reset)
      cmd.ext_step |-> (j_ff < n_ff))
      else $error("extension ran past the vertex count");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   typedef struct {
      bit                               is_cfg;
      logic [mcb_pkg::CNT_W-1:0]        cfg_value;
      logic [mcb_pkg::IDX_W-1:0]        row_index;
      logic [mcb_pkg::ROW_W-1:0]        row_bits;
      logic                             last_row;
   } pending_item_type;

   typedef struct {
      logic [mcb_pkg::CNT_W-1:0]        clique_size;
      logic [mcb_pkg::ROW_W-1:0]        clique_members;
   } clique_result_type;

   localparam int WATCHDOG_LIMIT = 1000000;

   logic                         clock;
   logic                         reset;
   logic                         csr_we;
   logic [mcb_pkg::CNT_W-1:0]    csr_wdata;

   mcb_req_if req_ch ();
   mcb_rsp_if rsp_ch ();

   max_clique_backtrack_search_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source)
   );

   pending_item_type  pending_q[$];
   clique_result_type expected_cliques[$];

   logic [mcb_pkg::ROW_W-1:0] graph_rows[32];
   logic [mcb_pkg::CNT_W-1:0] node_count;
   int               error_count = 0;
   int               quiet_cycles = 0;
   int               response_count = 0;
   int               idle_cycles = 0;
   int               send_gap = 0;
   int               recv_gap = 0;
   int               hold_cycles = 0;
   bit               hold_done = 0;
   bit               req_fire = 0;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // search predictor
   function automatic clique_result_type find_max_clique();
      clique_result_type res;
      int unsigned      n, s, j, k, last_m, resume, cur_size, best_size;
      logic [31:0]      cur_set, best_set;
      bit               joins, found;
      n = node_count;
      if (n > mcb_pkg::MAX_NODES_DEF) n = mcb_pkg::MAX_NODES_DEF;
      if (n > 32) n = 32;
      best_size = 0;
      best_set  = '0;
      for (s = 0; s < n; s++) begin
         cur_set  = 32'b1 << s;
         cur_size = 1;
         last_m   = s;
         resume   = s + 1;
         forever begin
            for (j = resume; j < n && best_size + j < cur_size + n; j++) begin
               joins = graph_rows[last_m][j];
               for (k = 0; k < j && joins; k++)
                  if (cur_set[k] && !graph_rows[k][j]) joins = 0;
               if (joins) begin
                  cur_set[j] = 1'b1;
                  last_m = j;
                  cur_size++;
               end
            end
            if (cur_size > best_size) begin
               best_size = cur_size;
               best_set  = cur_set;
            end
            cur_set[last_m] = 1'b0;
            cur_size--;
            resume = last_m + 1;
            found = 0;
            j = last_m;
            while (j > 0 && !found) begin
               j--;
               if (cur_set[j]) begin
                  last_m = j;
                  found = 1;
               end
            end
            if (!found) break;
         end
      end
      res.clique_size    = best_size[mcb_pkg::CNT_W-1:0];
      res.clique_members = best_set;
      return res;
   endfunction

   // request side: record accepted requests and csr writes, predict
   always @(posedge clock) begin
      if (reset) begin
         node_count = mcb_pkg::CNT_W'(32);
         quiet_cycles <= 0;
         req_fire     <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (csr_we)
            node_count = csr_wdata;
         if (req_ch.valid && req_ch.ready) begin
            graph_rows[req_ch.row_index] = req_ch.row_bits;
            if (req_ch.last_row)
               expected_cliques.push_back(find_max_clique());
            quiet_cycles <= 0;
         end else if (expected_cliques.size() == 0) begin
            quiet_cycles <= quiet_cycles + 1;
         end else begin
            quiet_cycles <= 0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      clique_result_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         response_count <= response_count + 1;
         if (expected_cliques.size() == 0) begin
            $display("%0t: unexpected response size=%0d members=%h", $time,
                     rsp_ch.clique_size, rsp_ch.clique_members);
            error_count++;
         end else begin
            exp_res = expected_cliques.pop_front();
            if (rsp_ch.clique_size !== exp_res.clique_size) begin
               $display("%0t: clique_size expected %0d actual %0d", $time,
                        exp_res.clique_size, rsp_ch.clique_size);
               error_count++;
            end
            if (rsp_ch.clique_members !== exp_res.clique_members) begin
               $display("%0t: clique_members expected %h actual %h", $time,
                        exp_res.clique_members, rsp_ch.clique_members);
               error_count++;
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      pending_item_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         csr_we       <= 1'b0;
      end else if (req_ch.valid && !req_fire) begin
         csr_we <= 1'b0;
      end else if (send_gap > 0) begin
         send_gap--;
         req_ch.valid <= 1'b0;
         csr_we       <= 1'b0;
      end else if (pending_q.size() == 0) begin
         req_ch.valid <= 1'b0;
         csr_we       <= 1'b0;
      end else if (pending_q[0].is_cfg) begin
         req_ch.valid <= 1'b0;
         if (!req_ch.valid && !csr_we && expected_cliques.size() == 0
             && quiet_cycles >= 16) begin
            item = pending_q.pop_front();
            csr_we    <= 1'b1;
            csr_wdata <= item.cfg_value;
         end else begin
            csr_we <= 1'b0;
         end
      end else begin
         item = pending_q.pop_front();
         csr_we           <= 1'b0;
         req_ch.valid     <= 1'b1;
         req_ch.row_index <= item.row_index;
         req_ch.row_bits  <= item.row_bits;
         req_ch.last_row  <= item.last_row;
         if (pending_q.size() > 80 && $urandom_range(0, 4) == 0)
            send_gap = $urandom_range(1, 3);
      end
   end

   // response ready, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && response_count >= 5) begin
         hold_done = 1;
         hold_cycles = 300;
         rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (pending_q.size() > 80 && $urandom_range(0, 4) == 0) begin
         recv_gap = $urandom_range(0, 2);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic void add_row(int idx, logic [31:0] bits, bit last);
      pending_item_type item;
      item.is_cfg    = 0;
      item.cfg_value = '0;
      item.row_index = idx[mcb_pkg::IDX_W-1:0];
      item.row_bits  = bits;
      item.last_row  = last;
      pending_q.push_back(item);
   endfunction

   function automatic void add_cfg(int value);
      pending_item_type item;
      item.is_cfg    = 1;
      item.cfg_value = value[mcb_pkg::CNT_W-1:0];
      item.row_index = '0;
      item.row_bits  = '0;
      item.last_row  = 1'b0;
      pending_q.push_back(item);
   endfunction

   // density: 0 empty, 1 sparse, 2 half, 3 dense, 4 complete
   function automatic logic [31:0] random_row(int density);
      case (density)
         0: return 32'h0;
         1: return $urandom() & $urandom();
         2: return $urandom();
         3: return $urandom() | $urandom();
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   initial begin
      int n, rows, density, graphs;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.row_index = '0;
      req_ch.row_bits = '0;
      req_ch.last_row = 1'b0;
      rsp_ch.ready = 1'b0;

      // complete graph, then degenerate counts
      add_cfg(32);
      for (int i = 0; i < 32; i++)
         add_row(i, 32'hFFFF_FFFF, i == 31);
      add_cfg(0);
      add_row(3, 32'h0000_0000, 1);
      add_cfg(1);
      add_row(0, 32'hFFFF_FFFF, 1);
      add_cfg(63);
      add_row(31, 32'h0000_0000, 1);
      add_cfg(33);
      add_row(0, 32'h0000_0000, 1);
      add_cfg(4);
      add_row(0, 32'h0000_000C, 0);
      add_row(2, 32'h0000_0008, 0);
      add_row(1, 32'h0000_0000, 1);

      // random graphs, mostly small
      n = 4;
      graphs = 0;
      while (pending_q.size() < 880) begin
         if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 15) == 0) begin
               n = ($urandom_range(0, 1) == 1) ? 63 : 32;
               add_cfg(n);
               density = $urandom_range(0, 4) == 0 ? 4 : $urandom_range(0, 2);
               for (int i = 0; i < 32; i++)
                  add_row(i, random_row(density), i == 31);
               n = 32;
               add_cfg(32);
               for (int i = 0; i < 32; i++)
                  add_row(i, random_row($urandom_range(0, 1)), i == 31);
               n = 6;
               add_cfg(n);
            end else begin
               n = $urandom_range(0, 14);
               add_cfg(n);
            end
         end
         density = $urandom_range(0, 4);
         if ($urandom_range(0, 9) == 0) begin
            // noise rows beyond the count, then a last row
            rows = $urandom_range(1, 4);
            for (int i = 0; i < rows; i++)
               add_row($urandom_range(n < 32 ? n : 0, 31), $urandom(), 0);
            add_row($urandom_range(0, 31), random_row(density), 1);
         end else begin
            rows = $urandom_range(0, n);
            for (int i = 0; i < rows; i++)
               add_row($urandom_range(0, n > 0 ? n - 1 : 0), random_row(density), 0);
            add_row($urandom_range(0, n > 0 ? n - 1 : 31), random_row(density), 1);
         end
         graphs++;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_q.size() == 0 && !req_ch.valid);
      wait (expected_cliques.size() == 0);
      repeat (50) @(posedge clock);

      if (error_count == 0 && expected_cliques.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
